[rtl/rccc_pkg.sv]
// Shared constants, codes and types for the resource charge / CPU credit unit.
package rccc_pkg;

    localparam int NCPU       = 4;
    localparam int CPU_W      = (NCPU > 1) ? $clog2(NCPU) : 1;
    localparam int SUM_W      = 32 + CPU_W;
    localparam int CREDIT_DIV = 2 * NCPU;
    localparam int BAR_W      = 31;
    localparam int DFLT_W     = 29;
    localparam int ADDR_W     = 4;

    localparam logic [31:0]       MAX_AMOUNT = 32'h7FFF_FFFF;
    localparam logic [31:0]       ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [DFLT_W-1:0] DFLT_RST   = 29'd256;
    localparam logic [BAR_W-1:0]  BAR_RST    = 31'h7FFF_FFFF;

    // operation codes
    localparam logic [2:0] MODE_CHARGE    = 3'd0;
    localparam logic [2:0] MODE_UNCHARGE  = 3'd1;
    localparam logic [2:0] MODE_FCHARGE   = 3'd2;
    localparam logic [2:0] MODE_FUNCHARGE = 3'd3;
    localparam logic [2:0] MODE_PRECHARGE = 3'd4;
    localparam logic [2:0] MODE_QUERY     = 3'd5;

    // severity codes
    localparam logic [1:0] SEV_HARD  = 2'd0;
    localparam logic [1:0] SEV_SOFT  = 2'd1;
    localparam logic [1:0] SEV_FORCE = 2'd2;
    localparam logic [1:0] SEV_BAD   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_BARRIER = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_DFLT    = 2'd2;

    typedef struct packed {
        logic        refuse;
        logic [31:0] held;
    } t_chg_res;

endpackage

[rtl/rccc_charge.sv]
// Charge check: saturating add of an amount to the held count against barrier and limit.
module rccc_charge (
    input  logic [31:0]             i_held,
    input  logic [32:0]             i_amount,
    input  logic [1:0]              i_sev,
    input  logic [30:0]             i_barrier,
    input  logic [30:0]             i_limit,
    output rccc_pkg::t_chg_res      o_res
);
    import rccc_pkg::*;

    logic [33:0] sum;
    logic [31:0] nv;
    logic        over_bar;
    logic        over_lim;

    assign sum      = {2'b00, i_held} + {1'b0, i_amount};
    assign nv       = (sum[33:32] != 2'b00) ? ALL_ONES : sum[31:0];
    assign over_bar = nv > {1'b0, i_barrier};
    assign over_lim = nv > {1'b0, i_limit};

    always_comb begin
        o_res.held = nv;
        case (i_sev)
            SEV_HARD: o_res.refuse = over_bar || over_lim;
            SEV_SOFT: o_res.refuse = over_lim;
            default:  o_res.refuse = 1'b0;
        endcase
    end

endmodule

[rtl/resource_charge_with_cpu_credit_unit.sv]
// Top level: resource counter with per-CPU cached credit, sequenced around a credit RAM.
//
// Input channel: i_valid / o_stall with mode, cpu, amount, severity, test_only.
// Output channel: o_valid / i_stall with status, usage and cpu_credit; one result
// beat per input beat, in order.
// Configuration: APB-style writes to barrier (0x0), limit (0x4), default
// precharge (0x8); writing default precharge also recomputes the credit bound.
// Per-CPU credit lives in a single-port RAM with a registered read. Each beat is a
// read-modify-write sequence: read at accept, then decide, charge, bound refresh
// and spill steps, then write back and update the running credit sum, then load
// the output register. Query, uncharge and a cache hit skip the charge step;
// charge, precharge and refill take it; a fast uncharge spill takes bound refresh
// and spill; a fast charge retry after a refused refill charges, refreshes the
// bound and charges again. Only one item is in flight, so RAM accesses never overlap.
// The result sits in an output register; the next beat is accepted while it waits.
// If i_stall holds a result when the next one is ready, the sequencer waits.
// Reset (synchronous, active low) clears counters, credit valid bits and the
// running sum and restores register defaults.
module resource_charge_with_cpu_credit_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_cpu,
    input  logic [31:0] i_amount,
    input  logic [1:0]  i_severity,
    input  logic        i_test_only,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_usage,
    output logic [31:0] o_cpu_credit,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rccc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rccc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_CHARGE, S_BOUND, S_UNCH, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [2:0]        r_mode, n_mode;
    logic [5:0]        r_cpu, n_cpu;
    logic [31:0]       r_amount, n_amount;
    logic [1:0]        r_sev, n_sev;
    logic              r_test, n_test;
    logic [32:0]       r_op, n_op;
    logic [1:0]        r_op_sev, n_op_sev;
    logic              r_op_test, n_op_test;
    logic              r_retry, n_retry;
    logic [DFLT_W-2:0] r_pre, n_pre;
    logic [31:0]       r_cr, n_cr;
    logic              r_wr, n_wr;
    logic [1:0]        r_status, n_status;
    logic [31:0]       r_held, n_held;
    logic [31:0]       r_peak, n_peak;
    logic [31:0]       r_fail, n_fail;
    logic [DFLT_W-1:0] r_bound, n_bound;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [BAR_W-1:0]  r_barrier, n_barrier;
    logic [BAR_W-1:0]  r_limit, n_limit;
    logic [DFLT_W-1:0] r_dflt, n_dflt;
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_out_status, n_out_status;
    logic [31:0]       r_out_usage, n_out_usage;
    logic [31:0]       r_out_credit, n_out_credit;

    // credit RAM
    logic [31:0]       mem [NCPU];
    logic [NCPU-1:0]   r_vld;
    logic [31:0]       r_rd_data;
    logic              r_rd_hit;

    logic              in_acc;
    logic              cfg_wr;
    logic              mem_wr;
    logic [31:0]       cr0;
    logic [DFLT_W-2:0] half;
    logic [31:0]       excess;
    logic [31:0]       share;
    logic [DFLT_W-1:0] bound_rc;
    logic [DFLT_W-1:0] bound_cfg;
    logic [31:0]       pre32;
    logic [31:0]       top32;
    logic [31:0]       unch32;
    logic [31:0]       total32;
    logic [31:0]       usage32;
    logic              bad;
    t_chg_res          chg;

    function automatic logic [DFLT_W-1:0] f_min_bound(input logic [DFLT_W-1:0] dflt,
                                                       input logic [31:0] shr);
        f_min_bound = ({3'b000, dflt} < shr) ? dflt : shr[DFLT_W-1:0];
    endfunction

    function automatic logic [31:0] f_uncharge(input logic [31:0] held,
                                               input logic [32:0] val);
        f_uncharge = (val >= {1'b0, held}) ? '0 : held - val[31:0];
    endfunction

    assign in_acc  = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign cfg_wr  = psel && penable && pwrite;
    assign mem_wr  = (r_state == S_FIN) && r_wr;
    assign pready  = 1'b1;

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_usage      = r_out_usage;
    assign o_cpu_credit = r_out_credit;

    assign cr0       = r_rd_hit ? r_rd_data : '0;
    assign half      = r_bound[DFLT_W-1:1];
    assign excess    = ({1'b0, r_limit} > r_held) ? {1'b0, r_limit} - r_held : '0;
    assign share     = excess / CREDIT_DIV;
    assign bound_rc  = f_min_bound(r_dflt, share);
    assign bound_cfg = f_min_bound(pwdata[DFLT_W-1:0], share);
    assign pre32     = ({4'b0000, half} > cr0) ? {4'b0000, half} - cr0 : '0;
    assign top32     = (r_amount > {4'b0000, half}) ? r_amount : {4'b0000, half};
    assign unch32    = (r_cr > {4'b0000, half}) ? r_cr - {4'b0000, half} : '0;
    assign total32   = (r_sum > SUM_W'(ALL_ONES)) ? ALL_ONES : r_sum[31:0];
    assign usage32   = (r_held > total32) ? r_held - total32 : '0;

    assign bad = (r_mode > MODE_QUERY) || ({1'b0, r_cpu} >= 7'(NCPU)) ||
                 ((r_mode <= MODE_PRECHARGE) && (r_amount > MAX_AMOUNT)) ||
                 (((r_mode == MODE_CHARGE) || (r_mode == MODE_FCHARGE)) &&
                  (r_sev == SEV_BAD));

    rccc_charge u_charge (
        .i_held    (r_held),
        .i_amount  (r_op),
        .i_sev     (r_op_sev),
        .i_barrier (r_barrier),
        .i_limit   (r_limit),
        .o_res     (chg)
    );

    always_comb begin
        unique case (paddr[3:2])
            REG_BARRIER: prdata = {1'b0, r_barrier};
            REG_LIMIT:   prdata = {1'b0, r_limit};
            REG_DFLT:    prdata = {3'b000, r_dflt};
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_cpu        = r_cpu;
        n_amount     = r_amount;
        n_sev        = r_sev;
        n_test       = r_test;
        n_op         = r_op;
        n_op_sev     = r_op_sev;
        n_op_test    = r_op_test;
        n_retry      = r_retry;
        n_pre        = r_pre;
        n_cr         = r_cr;
        n_wr         = r_wr;
        n_status     = r_status;
        n_held       = r_held;
        n_peak       = r_peak;
        n_fail       = r_fail;
        n_bound      = r_bound;
        n_sum        = r_sum;
        n_barrier    = r_barrier;
        n_limit      = r_limit;
        n_dflt       = r_dflt;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_usage  = r_out_usage;
        n_out_credit = r_out_credit;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode   = i_mode;
                    n_cpu    = i_cpu;
                    n_amount = i_amount;
                    n_sev    = i_severity;
                    n_test   = i_test_only;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                n_cr     = cr0;
                n_wr     = 1'b1;
                n_status = ST_OK;
                n_retry  = 1'b0;
                n_state  = S_FIN;
                if (bad) begin
                    n_status = ST_INVALID;
                    n_cr     = '0;
                    n_wr     = 1'b0;
                end else begin
                    case (r_mode)
                        MODE_CHARGE: begin
                            n_op      = {1'b0, r_amount};
                            n_op_sev  = r_sev;
                            n_op_test = r_test;
                            n_state   = S_CHARGE;
                        end
                        MODE_UNCHARGE: begin
                            n_held = f_uncharge(r_held, {1'b0, r_amount});
                        end
                        MODE_FCHARGE: begin
                            if (cr0 >= r_amount) begin
                                n_cr = cr0 - r_amount;
                            end else begin
                                // refill to half the bound along with this charge
                                n_pre     = pre32[DFLT_W-2:0];
                                n_op      = {1'b0, r_amount} + {1'b0, pre32};
                                n_op_sev  = SEV_SOFT;
                                n_op_test = 1'b1;
                                n_state   = S_CHARGE;
                            end
                        end
                        MODE_FUNCHARGE: begin
                            if (({1'b0, cr0} + {1'b0, r_amount}) <= {4'b0000, r_bound}) begin
                                n_cr = cr0 + r_amount;
                            end else begin
                                n_state = S_BOUND;
                            end
                        end
                        MODE_PRECHARGE: begin
                            if (cr0 < r_amount) begin
                                if (r_amount > {3'b000, r_bound}) begin
                                    n_status = ST_REFUSED;
                                end else begin
                                    n_op      = {1'b0, top32 - cr0};
                                    n_op_sev  = SEV_SOFT;
                                    n_op_test = 1'b1;
                                    n_state   = S_CHARGE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CHARGE: begin
                n_state = S_FIN;
                if (!chg.refuse) begin
                    n_held = chg.held;
                    if (chg.held > r_peak) begin
                        n_peak = chg.held;
                    end
                end else if (!r_op_test && (r_fail != ALL_ONES)) begin
                    n_fail = r_fail + 32'd1;
                end
                case (r_mode)
                    MODE_FCHARGE: begin
                        if (r_retry) begin
                            n_status = chg.refuse ? ST_REFUSED : ST_OK;
                        end else if (!chg.refuse) begin
                            n_cr = r_cr + {4'b0000, r_pre};
                        end else begin
                            n_retry = 1'b1;
                            n_state = S_BOUND;
                        end
                    end
                    MODE_PRECHARGE: begin
                        if (!chg.refuse) begin
                            n_cr = r_cr + r_op[31:0];
                        end else begin
                            n_status = ST_REFUSED;
                        end
                    end
                    default: begin
                        n_status = chg.refuse ? ST_REFUSED : ST_OK;
                    end
                endcase
            end
            S_BOUND: begin
                if ((r_mode == MODE_FCHARGE) || (r_bound != r_dflt)) begin
                    n_bound = bound_rc;
                end
                if (r_mode == MODE_FCHARGE) begin
                    n_op      = {1'b0, r_amount};
                    n_op_sev  = r_sev;
                    n_op_test = r_test;
                    n_state   = S_CHARGE;
                end else begin
                    n_state = S_UNCH;
                end
            end
            S_UNCH: begin
                // spill credit above half the bound back to the counter
                n_cr    = r_cr - unch32;
                n_held  = f_uncharge(r_held, {1'b0, r_amount} + {1'b0, unch32});
                n_state = S_FIN;
            end
            S_FIN: begin
                // invalid beats leave the RAM and the running sum alone
                if (r_wr) begin
                    n_sum = r_sum + SUM_W'(r_cr) - SUM_W'(cr0);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_usage  = usage32;
                    n_out_credit = r_cr;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BARRIER: n_barrier = pwdata[BAR_W-1:0];
                REG_LIMIT:   n_limit   = pwdata[BAR_W-1:0];
                REG_DFLT: begin
                    n_dflt  = pwdata[DFLT_W-1:0];
                    n_bound = bound_cfg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_peak      <= '0;
            r_fail      <= '0;
            r_bound     <= DFLT_RST;
            r_sum       <= '0;
            r_barrier   <= BAR_RST;
            r_limit     <= BAR_RST;
            r_dflt      <= DFLT_RST;
            r_out_valid <= 1'b0;
            r_wr        <= 1'b0;
            r_retry     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_peak      <= n_peak;
            r_fail      <= n_fail;
            r_bound     <= n_bound;
            r_sum       <= n_sum;
            r_barrier   <= n_barrier;
            r_limit     <= n_limit;
            r_dflt      <= n_dflt;
            r_out_valid <= n_out_valid;
            r_wr        <= n_wr;
            r_retry     <= n_retry;
        end
        r_mode       <= n_mode;
        r_cpu        <= n_cpu;
        r_amount     <= n_amount;
        r_sev        <= n_sev;
        r_test       <= n_test;
        r_op         <= n_op;
        r_op_sev     <= n_op_sev;
        r_op_test    <= n_op_test;
        r_pre        <= n_pre;
        r_cr         <= n_cr;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_usage  <= n_out_usage;
        r_out_credit <= n_out_credit;
    end

    // credit RAM: read at accept, write back at the end of the sequence
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_data <= mem[i_cpu[CPU_W-1:0]];
        end
        if (mem_wr) begin
            mem[r_cpu[CPU_W-1:0]] <= r_cr;
        end
    end

    // per-entry valid bits; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (in_acc) begin
                r_rd_hit <= r_vld[i_cpu[CPU_W-1:0]];
            end
            if (mem_wr) begin
                r_vld[r_cpu[CPU_W-1:0]] <= 1'b1;
            end
        end
    end

endmodule

[test/rccc_checker.sv]
// Checker for the resource charge unit: tracks counter and credit state, predicts and compares.
`timescale 1ns / 100ps

module rccc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [2:0]                    i_mode,
    input  logic [5:0]                    i_cpu,
    input  logic [31:0]                   i_amount,
    input  logic [1:0]                    i_severity,
    input  logic                          i_test_only,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [1:0]                    o_status,
    input  logic [31:0]                   o_usage,
    input  logic [31:0]                   o_cpu_credit,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rccc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          pready,
    output int                            o_fails,
    output int                            o_pending
);
    import rccc_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] usage;
        logic [31:0] credit;
    } t_outcome;

    logic [BAR_W-1:0]  cfg_barrier;
    logic [BAR_W-1:0]  cfg_limit;
    logic [DFLT_W-1:0] cfg_dflt;

    logic [31:0] held;
    logic [31:0] peak;
    logic [31:0] refusals;
    logic [31:0] bound;
    logic [31:0] total;
    logic [31:0] credit [NCPU];

    t_outcome owed_results [$];
    int       mismatches;

    function automatic void refresh_bound();
        logic [31:0] excess;
        logic [31:0] share;
        excess = ({1'b0, cfg_limit} > held) ? {1'b0, cfg_limit} - held : 32'd0;
        share  = excess / 32'(CREDIT_DIV);
        bound  = ({3'b0, cfg_dflt} < share) ? {3'b0, cfg_dflt} : share;
    endfunction

    // returns 1 when the charge is refused
    function automatic logic try_charge(logic [63:0] val, logic [1:0] sev, logic dry);
        logic [63:0] sum;
        logic [31:0] nv;
        logic        refuse;
        sum    = {32'd0, held} + val;
        nv     = (sum > {32'd0, ALL_ONES}) ? ALL_ONES : sum[31:0];
        refuse = (sev == SEV_HARD && (nv > {1'b0, cfg_barrier} || nv > {1'b0, cfg_limit})) ||
                 (sev == SEV_SOFT && nv > {1'b0, cfg_limit});
        if (!refuse) begin
            held = nv;
            if (nv > peak)
                peak = nv;
        end else if (!dry && refusals != ALL_ONES) begin
            refusals = refusals + 32'd1;
        end
        return refuse;
    endfunction

    function automatic void release_held(logic [63:0] val);
        if (val >= {32'd0, held})
            held = 32'd0;
        else
            held = held - val[31:0];
    endfunction

    function automatic t_outcome account_request(logic [2:0] mode, logic [5:0] cpu,
                                                  logic [31:0] amt, logic [1:0] sev,
                                                  logic dry);
        t_outcome    res;
        logic [31:0] cr;
        logic [31:0] half;
        logic [31:0] pre;
        logic [31:0] unch;
        logic [31:0] top;
        logic [31:0] chg;
        logic [63:0] sum;
        int          idx;
        res.status = ST_OK;
        res.credit = 32'd0;
        if (mode > MODE_QUERY || cpu >= NCPU || (mode <= MODE_PRECHARGE && amt > MAX_AMOUNT) ||
            ((mode == MODE_CHARGE || mode == MODE_FCHARGE) && sev == SEV_BAD)) begin
            res.status = ST_INVALID;
        end else begin
            idx  = int'(cpu);
            cr   = credit[idx];
            half = bound >> 1;
            case (mode)
                MODE_CHARGE: begin
                    res.status = try_charge({32'd0, amt}, sev, dry) ? ST_REFUSED : ST_OK;
                end
                MODE_UNCHARGE: begin
                    release_held({32'd0, amt});
                end
                MODE_FCHARGE: begin
                    if (cr >= amt) begin
                        cr = cr - amt;
                    end else begin
                        pre = (half > cr) ? half - cr : 32'd0;
                        if (!try_charge({32'd0, amt} + {32'd0, pre}, SEV_SOFT, 1'b1)) begin
                            cr = cr + pre;
                        end else begin
                            // refill refused: tighten the bound, then try the bare amount
                            refresh_bound();
                            res.status = try_charge({32'd0, amt}, sev, dry) ? ST_REFUSED : ST_OK;
                        end
                    end
                end
                MODE_FUNCHARGE: begin
                    if ({32'd0, cr} + {32'd0, amt} <= {32'd0, bound}) begin
                        cr = cr + amt;
                    end else begin
                        if (bound != {3'b0, cfg_dflt})
                            refresh_bound();
                        half = bound >> 1;
                        unch = (cr > half) ? cr - half : 32'd0;
                        cr   = cr - unch;
                        release_held({32'd0, amt} + {32'd0, unch});
                    end
                end
                MODE_PRECHARGE: begin
                    if (cr < amt) begin
                        if (amt > bound) begin
                            res.status = ST_REFUSED;
                        end else begin
                            top = (amt > half) ? amt : half;
                            chg = top - cr;
                            if (!try_charge({32'd0, chg}, SEV_SOFT, 1'b1))
                                cr = cr + chg;
                            else
                                res.status = ST_REFUSED;
                        end
                    end
                end
                default: begin
                end
            endcase
            credit[idx] = cr;
            sum = 64'd0;
            for (int k = 0; k < NCPU; k++)
                sum = sum + {32'd0, credit[k]};
            total = (sum > {32'd0, ALL_ONES}) ? ALL_ONES : sum[31:0];
            res.credit = credit[idx];
        end
        res.usage = (held > total) ? held - total : 32'd0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            cfg_barrier = BAR_RST;
            cfg_limit   = BAR_RST;
            cfg_dflt    = DFLT_RST;
            held        = 32'd0;
            peak        = 32'd0;
            refusals    = 32'd0;
            bound       = {3'b0, DFLT_RST};
            total       = 32'd0;
            for (int k = 0; k < NCPU; k++)
                credit[k] = 32'd0;
            owed_results.delete();
            mismatches  = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BARRIER: cfg_barrier = pwdata[BAR_W-1:0];
                    REG_LIMIT:   cfg_limit   = pwdata[BAR_W-1:0];
                    REG_DFLT: begin
                        cfg_dflt = pwdata[DFLT_W-1:0];
                        refresh_bound();
                    end
                    default: begin
                    end
                endcase
            end
            if (i_valid && !o_stall)
                owed_results.push_back(account_request(i_mode, i_cpu, i_amount,
                                                       i_severity, i_test_only));
            if (o_valid && !i_stall) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing owed (status %0d usage %0d credit %0d)",
                             $time, o_status, o_usage, o_cpu_credit);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                        mismatches++;
                    end
                    if (o_usage !== want.usage) begin
                        $display("%0t: usage expected %0d got %0d", $time, want.usage, o_usage);
                        mismatches++;
                    end
                    if (o_cpu_credit !== want.credit) begin
                        $display("%0t: cpu_credit expected %0d got %0d", $time, want.credit,
                                 o_cpu_credit);
                        mismatches++;
                    end
                end
            end
        end
        o_fails   <= mismatches;
        o_pending <= owed_results.size();
    end

endmodule

[test/testbench.sv]
// Testbench top: drives beats and register writes into the resource charge unit and reports.
`timescale 1ns / 100ps

module testbench;
    import rccc_pkg::*;

    localparam logic [2:0] MODE_BAD_LO = 3'd6;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;
    localparam int         HOLD_CYCLES = 150;
    localparam int         QUIET_LIMIT = 4000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [2:0]        i_mode;
    logic [5:0]        i_cpu;
    logic [31:0]       i_amount;
    logic [1:0]        i_severity;
    logic              i_test_only;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_status;
    logic [31:0]       o_usage;
    logic [31:0]       o_cpu_credit;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int fails;
    int pending;
    int quiet;
    bit calm;
    bit hold_req;

    resource_charge_with_cpu_credit_unit u_top (.*);

    rccc_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_cpu, .i_amount, .i_severity,
        .i_test_only, .o_valid, .i_stall, .o_status, .o_usage, .o_cpu_credit,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fails(fails), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 6);
            end
        end
    end

    // no progress on any channel for too long means a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (psel && penable && pready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic offer(input logic [2:0] mode, input logic [5:0] cpu, input logic [31:0] amt,
                         input logic [1:0] sev, input logic dry);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 6)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_cpu       <= cpu;
        i_amount    <= amt;
        i_severity  <= sev;
        i_test_only <= dry;
        do @(posedge i_clk); while (o_stall);
    endtask

    // drop valid and wait until every owed result has come back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_run(input int count, input logic [31:0] scale, input bit with_calm);
        logic [2:0]  mode;
        logic [5:0]  cpu;
        logic [31:0] amt;
        logic [1:0]  sev;
        for (int n = 0; n < count; n++) begin
            calm = with_calm && n >= count / 4 && n < count * 3 / 4;
            if ($urandom_range(0, 99) < 3)
                mode = $urandom_range(0, 1) ? MODE_BAD_HI : MODE_BAD_LO;
            else
                mode = 3'($urandom_range(0, 5));
            cpu = ($urandom_range(0, 99) < 4) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, NCPU - 1));
            sev = ($urandom_range(0, 99) < 5) ? SEV_BAD : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0:       amt = $urandom_range(0, 3);
                1, 2, 3: amt = $urandom_range(0, 600);
                4, 5, 6: amt = $urandom_range(0, scale);
                7:       amt = $urandom;
                8: begin
                    case ($urandom_range(0, 3))
                        0:       amt = 32'd0;
                        1:       amt = MAX_AMOUNT;
                        2:       amt = MAX_AMOUNT + 32'd1;
                        default: amt = ALL_ONES;
                    endcase
                end
                default: amt = $urandom_range(0, MAX_AMOUNT);
            endcase
            offer(mode, cpu, amt, sev, 1'($urandom_range(0, 1)));
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = MODE_QUERY;
        i_cpu       = 6'd0;
        i_amount    = 32'd0;
        i_severity  = SEV_HARD;
        i_test_only = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = 32'd0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults give a credit bound of 256
        offer(MODE_QUERY,     6'd0,  32'd0,            SEV_HARD,  1'b0);
        offer(MODE_CHARGE,    6'd0,  32'd100,          SEV_HARD,  1'b0);
        offer(MODE_UNCHARGE,  6'd0,  32'd500,          SEV_HARD,  1'b0);
        offer(MODE_CHARGE,    6'd1,  32'd100,          SEV_SOFT,  1'b0);
        offer(MODE_CHARGE,    6'd1,  MAX_AMOUNT,       SEV_HARD,  1'b0);
        offer(MODE_CHARGE,    6'd2,  MAX_AMOUNT,       SEV_SOFT,  1'b1);
        offer(MODE_CHARGE,    6'd3,  MAX_AMOUNT + 1,   SEV_HARD,  1'b0);
        offer(MODE_UNCHARGE,  6'd0,  ALL_ONES,         SEV_FORCE, 1'b0);
        offer(MODE_CHARGE,    6'd0,  32'd5,            SEV_BAD,   1'b0);
        offer(MODE_FCHARGE,   6'd1,  32'd5,            SEV_BAD,   1'b0);
        offer(MODE_QUERY,     6'd4,  32'd0,            SEV_HARD,  1'b0);
        offer(MODE_QUERY,     6'd63, ALL_ONES,         SEV_BAD,   1'b1);
        offer(MODE_BAD_LO,    6'd0,  32'd1,            SEV_HARD,  1'b0);
        offer(MODE_BAD_HI,    6'd0,  32'd1,            SEV_HARD,  1'b0);
        offer(MODE_FCHARGE,   6'd1,  32'd10,           SEV_HARD,  1'b0);
        offer(MODE_FCHARGE,   6'd1,  32'd50,           SEV_HARD,  1'b0);
        offer(MODE_FCHARGE,   6'd2,  MAX_AMOUNT,       SEV_HARD,  1'b0);
        offer(MODE_FUNCHARGE, 6'd1,  32'd20,           SEV_HARD,  1'b0);
        offer(MODE_FUNCHARGE, 6'd1,  32'd1000,         SEV_HARD,  1'b0);
        offer(MODE_PRECHARGE, 6'd3,  32'd1000,         SEV_HARD,  1'b0);
        offer(MODE_PRECHARGE, 6'd3,  32'd200,          SEV_HARD,  1'b0);
        offer(MODE_PRECHARGE, 6'd3,  32'd50,           SEV_HARD,  1'b0);
        // force charges past all-ones: held saturates
        repeat (3) offer(MODE_CHARGE, 6'd0, MAX_AMOUNT, SEV_FORCE, 1'b0);
        repeat (3) offer(MODE_UNCHARGE, 6'd2, MAX_AMOUNT, SEV_HARD, 1'b0);

        // receiver holds off while the sender keeps offering
        hold_req = 1'b1;
        random_run(200, 32'd4096, 1'b0);
        settle();

        reg_write(REG_BARRIER, 32'd3000);
        reg_write(REG_LIMIT, 32'd6000);
        reg_write(REG_DFLT, 32'd600);
        random_run(200, 32'd2000, 1'b1);
        settle();

        reg_write(REG_BARRIER, 32'd0);
        reg_write(REG_LIMIT, 32'd0);
        reg_write(REG_DFLT, 32'd0);
        random_run(150, 32'd64, 1'b0);
        settle();

        reg_write(REG_BARRIER, {1'b0, BAR_RST});
        reg_write(REG_LIMIT, ALL_ONES);
        reg_write(REG_DFLT, ALL_ONES);
        random_run(200, 32'h00FF_FFFF, 1'b0);
        settle();

        reg_write(REG_BARRIER, $urandom_range(0, 1 << 20));
        reg_write(REG_LIMIT, $urandom_range(0, 1 << 21));
        reg_write(REG_DFLT, $urandom_range(0, 4096));
        random_run(120, 32'd1 << 20, 1'b0);
        settle();

        reg_write(REG_BARRIER, $urandom);
        reg_write(REG_LIMIT, $urandom);
        reg_write(REG_DFLT, $urandom);
        random_run(80, 32'h0FFF_FFFF, 1'b0);
        settle();

        repeat (10) @(posedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
rtl/rccc_pkg.sv
rtl/rccc_charge.sv
rtl/resource_charge_with_cpu_credit_unit.sv
test/rccc_checker.sv
test/testbench.sv
